// ----- src/bba_pkg.sv -----
// Shared types and codes for the bitmap block allocator.
package bba_pkg;

    // Operation codes carried on the input tuser
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_BAD_FREE = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_FREE,
        S_DONE
    } state_t;

    // Control from the sequencer to the bitmap store
    typedef struct packed {
        logic wr_en;
        logic clear;
    } mem_ctl_t;

endpackage

// ----- src/bitmap_block_allocator_core.sv -----
// Top level of the bitmap block allocator with stream ports and output register.
// An allocate reads from 1 to WORD_COUNT bitmap words, one per cycle, starting at the hint
// word, until it finds a free bit. The sequencer finishes each request, with its bitmap
// read-modify-write, before it takes the next one. Reset frees all MAX_BLOCKS blocks
// and clears the hint; per-word valid bits stand in for a clearing pass, so no wait follows.
module bitmap_block_allocator_core
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024,
    parameter int WORD_BITS  = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // config register block_count
    input  logic                            cfg_we,
    input  logic [$clog2(MAX_BLOCKS):0]     cfg_data,
    // input: tuser = func; tdata = free_index
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic                            s_tuser,
    input  logic [((($clog2(MAX_BLOCKS))+7)/8)*8-1:0] s_tdata,
    // output: tdata = given_index, status
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [((($clog2(MAX_BLOCKS))+2+7)/8)*8-1:0] m_tdata
);

    localparam int IW         = $clog2(MAX_BLOCKS);
    localparam int CW         = IW + 1;
    localparam int WORD_COUNT = MAX_BLOCKS / WORD_BITS;
    localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int OW         = ((IW + 2 + 7) / 8) * 8;

    mem_ctl_t             mem_ctl;
    logic [AW-1:0]        raddr;
    logic [AW-1:0]        waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [WORD_BITS-1:0] rdata;
    logic [CW-1:0]        block_count;
    logic                 res_valid;
    logic                 res_ready;
    logic [IW-1:0]        res_index;
    status_t              res_status;
    logic                 out_valid_reg;
    logic [OW-1:0]        out_data_reg;

    bba_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .WORD_BITS  (WORD_BITS),
        .WORD_COUNT (WORD_COUNT),
        .AW         (AW),
        .IW         (IW),
        .CW         (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_func     (s_tuser),
        .in_index    (s_tdata[IW-1:0]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_index   (res_index),
        .res_status  (res_status),
        .mem_ctl     (mem_ctl),
        .raddr       (raddr),
        .waddr       (waddr),
        .wdata       (wdata),
        .block_count (block_count),
        .rdata       (rdata)
    );

    bba_bitmap #(
        .WORD_BITS  (WORD_BITS),
        .WORD_COUNT (WORD_COUNT),
        .AW         (AW),
        .CW         (CW)
    ) u_bitmap (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (mem_ctl),
        .raddr       (raddr),
        .waddr       (waddr),
        .wdata       (wdata),
        .block_count (block_count),
        .rdata       (rdata)
    );

    // Output register: takes a result when empty or being drained
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= OW'({res_status, res_index});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- src/bba_bitmap.sv -----
// Free bitmap store: word memory with per-word valid bits and fill pattern.
module bba_bitmap
    import bba_pkg::*;
#(
    parameter int WORD_BITS  = 32,
    parameter int WORD_COUNT = 32,
    parameter int AW         = 5,
    parameter int CW         = 11
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mem_ctl_t             ctl,
    input  logic [AW-1:0]        raddr,
    input  logic [AW-1:0]        waddr,
    input  logic [WORD_BITS-1:0] wdata,
    input  logic [CW-1:0]        block_count,
    output logic [WORD_BITS-1:0] rdata
);

    localparam int BW = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0]  mem [WORD_COUNT];
    logic [WORD_COUNT-1:0] valid_reg;
    logic [WORD_BITS-1:0]  rdata_reg;
    logic [AW-1:0]         raddr_reg;
    logic                  rvalid_reg;
    logic [WORD_BITS-1:0]  fill_word;

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
        raddr_reg <= raddr;
    end

    // Valid bits: an unwritten word reads as its post-clear pattern
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[raddr];
        end
    end

    // Blocks below the block count are free after a clear
    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            fill_word[i] = ({1'b0, raddr_reg, BW'(i)} < block_count);
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : fill_word;

endmodule

// ----- src/bba_ctrl.sv -----
// Allocator sequencer: hint check, word scan, free update and counters.
module bba_ctrl
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024,
    parameter int WORD_BITS  = 32,
    parameter int WORD_COUNT = 32,
    parameter int AW         = 5,
    parameter int IW         = 10,
    parameter int CW         = 11
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // config
    input  logic                 cfg_we,
    input  logic [CW-1:0]        cfg_data,
    // request
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_func,
    input  logic [IW-1:0]        in_index,
    // result
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic [IW-1:0]        res_index,
    output status_t              res_status,
    // bitmap store
    output mem_ctl_t             mem_ctl,
    output logic [AW-1:0]        raddr,
    output logic [AW-1:0]        waddr,
    output logic [WORD_BITS-1:0] wdata,
    output logic [CW-1:0]        block_count,
    input  logic [WORD_BITS-1:0] rdata
);

    localparam int BW = $clog2(WORD_BITS);

    state_t        state_reg, state_next;
    logic [AW-1:0] scan_reg, scan_next;
    logic          first_reg, first_next;
    logic [IW-1:0] hint_reg, hint_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] bcount_reg, bcount_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] rindex_reg, rindex_next;
    status_t       rstatus_reg, rstatus_next;

    logic          accept;
    logic [AW-1:0] scan_inc;
    logic [BW-1:0] lo_bit;
    logic          any_free;
    logic          hint_hit;
    logic [BW-1:0] sel_bit;
    logic          out_of_range;
    logic          free_bit;
    logic [CW-1:0] cfg_sat;

    assign accept       = in_valid && in_ready;
    assign scan_inc     = (scan_reg == AW'(WORD_COUNT - 1)) ? '0 : scan_reg + 1'b1;
    assign hint_hit     = first_reg && rdata[hint_reg[BW-1:0]];
    assign sel_bit      = hint_hit ? hint_reg[BW-1:0] : lo_bit;
    assign out_of_range = ({1'b0, in_index} >= bcount_reg);
    assign free_bit     = rdata[idx_reg[BW-1:0]];
    assign cfg_sat      = (cfg_data > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : cfg_data;

    // Lowest free bit of the word just read
    always_comb
    begin
        lo_bit   = '0;
        any_free = |rdata;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (rdata[i])
            begin
                lo_bit = BW'(i);
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_func == FUNC_ALLOC)
                    begin
                        state_next = (count_reg == '0) ? S_DONE : S_CHECK;
                    end
                    else
                    begin
                        state_next = out_of_range ? S_DONE : S_FREE;
                    end
                end
            end
            S_CHECK:
            begin
                if (hint_hit || any_free)
                begin
                    state_next = S_DONE;
                end
            end
            S_FREE:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs and memory access
    always_comb
    begin
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        mem_ctl.wr_en = 1'b0;
        mem_ctl.clear = cfg_we;
        raddr         = scan_reg;
        waddr         = scan_reg;
        wdata         = rdata;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                raddr    = (in_func == FUNC_FREE) ? in_index[IW-1:BW] : hint_reg[IW-1:BW];
            end
            S_CHECK:
            begin
                raddr = scan_inc;
                if (hint_hit || any_free)
                begin
                    mem_ctl.wr_en = 1'b1;
                    wdata         = rdata & ~(WORD_BITS'(1) << sel_bit);
                end
            end
            S_FREE:
            begin
                if (!free_bit)
                begin
                    mem_ctl.wr_en = 1'b1;
                    wdata         = rdata | (WORD_BITS'(1) << idx_reg[BW-1:0]);
                end
            end
            S_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        scan_next    = scan_reg;
        first_next   = first_reg;
        hint_next    = hint_reg;
        count_next   = count_reg;
        bcount_next  = bcount_reg;
        idx_next     = idx_reg;
        rindex_next  = rindex_reg;
        rstatus_next = rstatus_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next     = in_index;
                    first_next   = 1'b1;
                    rindex_next  = '0;
                    rstatus_next = ST_OK;
                    if (in_func == FUNC_ALLOC)
                    begin
                        scan_next = hint_reg[IW-1:BW];
                        if (count_reg == '0)
                        begin
                            rstatus_next = ST_EMPTY;
                        end
                    end
                    else
                    begin
                        scan_next = in_index[IW-1:BW];
                        if (out_of_range)
                        begin
                            rstatus_next = ST_BAD_FREE;
                        end
                    end
                end
            end
            S_CHECK:
            begin
                if (hint_hit || any_free)
                begin
                    rindex_next = {scan_reg, sel_bit};
                    count_next  = count_reg - 1'b1;
                    if (!hint_hit)
                    begin
                        hint_next = {scan_reg, {BW{1'b0}}};
                    end
                end
                else
                begin
                    scan_next  = scan_inc;
                    first_next = 1'b0;
                end
            end
            S_FREE:
            begin
                if (free_bit)
                begin
                    rstatus_next = ST_BAD_FREE;
                end
                else
                begin
                    hint_next  = idx_reg;
                    count_next = count_reg + 1'b1;
                end
            end
            default:
            begin
                scan_next = scan_reg;
            end
        endcase
        // Register write clears the allocator
        if (cfg_we)
        begin
            bcount_next = cfg_sat;
            count_next  = cfg_sat;
            hint_next   = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            hint_reg   <= '0;
            count_reg  <= CW'(MAX_BLOCKS);
            bcount_reg <= CW'(MAX_BLOCKS);
            first_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            hint_reg   <= hint_next;
            count_reg  <= count_next;
            bcount_reg <= bcount_next;
            first_reg  <= first_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        scan_reg    <= scan_next;
        idx_reg     <= idx_next;
        rindex_reg  <= rindex_next;
        rstatus_reg <= rstatus_next;
    end

    assign res_index   = rindex_reg;
    assign res_status  = rstatus_reg;
    assign block_count = bcount_reg;

endmodule
